// File: rtl/core/psfc_pkg.sv
`default_nettype none

package psfc_pkg;

	// Width of one received byte and of the assembled data word.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;

	// Output field widths.
	localparam int unsigned ANGLE_W = 14;
	localparam int unsigned OUT_COUNT_W = 16;
	localparam int unsigned STATUS_W = 2;

	// Default width of the internal saturating tallies.
	localparam int unsigned COUNT_WIDTH_DEF = 16;

	// Byte positions inside the ten-byte reply frame.
	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] POS_DATA_HIGH = 4'd2;
	localparam logic [POS_W-1:0] POS_DATA_LOW = 4'd3;
	localparam logic [POS_W-1:0] POS_INV_HIGH = 4'd4;
	localparam logic [POS_W-1:0] POS_INV_LOW = 4'd5;
	localparam logic [POS_W-1:0] POS_LAST = 4'd9;
	localparam logic [POS_W-1:0] POS_IDLE = 4'd10;

	// Value of every fill byte.
	localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

	// Result kinds.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_ANGLE = 2'd0,
		STATUS_SENSOR_ERR = 2'd1,
		STATUS_FRAME_BAD = 2'd2
	} status_t;

	// Summary of a frame that closes with the byte now in the input stage.
	typedef struct packed {
		logic done;
		logic good;
		logic [WORD_W-1:0] word;
	} frame_end_t;

endpackage

`default_nettype wire

// File: rtl/core/position_sensor_frame_checker.sv
`default_nettype none

// Channel   Direction  tdata                              tuser
// s_axis    in         [7:0] rx_byte                      [0] frame_start
// m_axis    out        [13:0] angle, [29:14] error_word,  [1:0] frame_status
//                      [45:30] data_error_count,
//                      [61:46] frame_error_count, [63:62] zero
//
// One byte is taken per cycle while s_axis_tready is high; each byte passes
// an input register, and after the tenth byte its result lands in the result register.
// While a result waits, the input register still takes one more byte;
// s_axis_tready then stays low, since it falls when both registers are full
// and m_axis is stalled. Reset leaves the tracker idle with all tallies and
// held values at zero; no clearing pass is needed.

module position_sensor_frame_checker #(
	parameter int unsigned COUNT_WIDTH = psfc_pkg::COUNT_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	input wire logic s_axis_tuser,         // [0] frame_start
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [63:0] m_axis_tdata,      // angle, error_word, data and frame error counts
	output logic [1:0] m_axis_tuser        // [1:0] frame_status
);

	psfc_pkg::frame_end_t frame_end;
	psfc_pkg::status_t status;
	logic advance;
	logic [psfc_pkg::ANGLE_W-1:0] angle;
	logic [psfc_pkg::WORD_W-1:0] error_word;
	logic [psfc_pkg::OUT_COUNT_W-1:0] data_err_cnt;
	logic [psfc_pkg::OUT_COUNT_W-1:0] frame_err_cnt;

	// Frame position tracking and byte checks.
	psfc_frame_track u_track (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_byte(s_axis_tdata),
		.in_start(s_axis_tuser),
		.advance(advance),
		.frame_end(frame_end)
	);

	// Held values, tallies and the result register.
	psfc_result_reg #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_result (
		.clk(clk),
		.arst_n(arst_n),
		.frame_end(frame_end),
		.advance(advance),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_status(status),
		.out_angle(angle),
		.out_error_word(error_word),
		.out_data_err_cnt(data_err_cnt),
		.out_frame_err_cnt(frame_err_cnt)
	);

	// Output packing.
	assign m_axis_tuser = status;
	assign m_axis_tdata = {2'b00, frame_err_cnt, data_err_cnt, error_word, angle};

endmodule

`default_nettype wire

// File: rtl/core/psfc_frame_track.sv
`default_nettype none

module psfc_frame_track (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [psfc_pkg::BYTE_W-1:0] in_byte,
	input wire logic in_start,
	input wire logic advance,
	output psfc_pkg::frame_end_t frame_end
);

	logic valid_s1;
	logic [psfc_pkg::BYTE_W-1:0] byte_s1;
	logic start_s1;

	logic [psfc_pkg::POS_W-1:0] pos_q;
	logic fill_ok_q;
	logic comp_ok_q;
	logic [psfc_pkg::BYTE_W-1:0] data_high_q;
	logic [psfc_pkg::BYTE_W-1:0] data_low_q;

	logic [psfc_pkg::POS_W-1:0] pos_cur;
	logic active;
	logic fill_ok_nx;
	logic comp_ok_nx;
	logic fire;

	// The input stage moves on whenever the result side can take what it makes.
	assign in_ready = !valid_s1 || advance;
	assign fire = valid_s1 && advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			start_s1 <= in_start;
		end
	end

	// Position of the byte in the stage; a start marker restarts the frame.
	assign pos_cur = start_s1 ? '0 : pos_q;
	assign active = start_s1 || (pos_q < psfc_pkg::POS_IDLE);

	// Per-position check of the current byte.
	always_comb begin
		fill_ok_nx = start_s1 ? 1'b1 : fill_ok_q;
		comp_ok_nx = start_s1 ? 1'b1 : comp_ok_q;
		unique case (pos_cur)
			psfc_pkg::POS_DATA_HIGH, psfc_pkg::POS_DATA_LOW: begin
			end
			psfc_pkg::POS_INV_HIGH: begin
				if (byte_s1 != ~data_high_q) comp_ok_nx = 1'b0;
			end
			psfc_pkg::POS_INV_LOW: begin
				if (byte_s1 != ~data_low_q) comp_ok_nx = 1'b0;
			end
			default: begin
				if (byte_s1 != psfc_pkg::FILL_BYTE) fill_ok_nx = 1'b0;
			end
		endcase
	end

	// Frame state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= psfc_pkg::POS_IDLE;
			fill_ok_q <= 1'b1;
			comp_ok_q <= 1'b1;
			data_high_q <= '0;
			data_low_q <= '0;
		end else if (fire) begin
			if (!active) begin
				pos_q <= psfc_pkg::POS_IDLE;
			end else begin
				fill_ok_q <= fill_ok_nx;
				comp_ok_q <= comp_ok_nx;
				if (pos_cur == psfc_pkg::POS_DATA_HIGH) data_high_q <= byte_s1;
				if (pos_cur == psfc_pkg::POS_DATA_LOW) data_low_q <= byte_s1;
				if (pos_cur == psfc_pkg::POS_LAST) begin
					pos_q <= psfc_pkg::POS_IDLE;
				end else begin
					pos_q <= pos_cur + 1'b1;
				end
			end
		end
	end

	// Frame summary toward the result stage: done, good, then the data word.
	assign frame_end = {valid_s1 && active && (pos_cur == psfc_pkg::POS_LAST),
		fill_ok_nx && comp_ok_nx, data_high_q, data_low_q};

	// Position never leaves the frame range.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= psfc_pkg::POS_IDLE)
		else $error("frame position out of range");

	// A closed frame always returns the tracker to idle.
	a_close_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && frame_end.done) |=> (pos_q == psfc_pkg::POS_IDLE))
		else $error("tracker not idle after frame end");

	// Bytes that arrive while idle leave the position at idle.
	a_idle_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !active) |=> (pos_q == psfc_pkg::POS_IDLE))
		else $error("idle byte moved the position");

endmodule

`default_nettype wire

// File: rtl/core/psfc_result_reg.sv
`default_nettype none

module psfc_result_reg #(
	parameter int unsigned COUNT_WIDTH = psfc_pkg::COUNT_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire psfc_pkg::frame_end_t frame_end,
	output logic advance,
	output logic out_valid,
	input wire logic out_ready,
	output psfc_pkg::status_t out_status,
	output logic [psfc_pkg::ANGLE_W-1:0] out_angle,
	output logic [psfc_pkg::WORD_W-1:0] out_error_word,
	output logic [psfc_pkg::OUT_COUNT_W-1:0] out_data_err_cnt,
	output logic [psfc_pkg::OUT_COUNT_W-1:0] out_frame_err_cnt
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = {COUNT_WIDTH{1'b1}};

	logic valid_q;
	psfc_pkg::status_t status_q;
	logic [psfc_pkg::ANGLE_W-1:0] angle_q;
	logic [psfc_pkg::WORD_W-1:0] error_q;
	logic [COUNT_WIDTH-1:0] data_err_q;
	logic [COUNT_WIDTH-1:0] frame_err_q;
	logic load;

	// The result register is free when empty or being read this cycle.
	assign advance = !valid_q || out_ready;
	assign load = frame_end.done && advance;

	// Result register and held values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			status_q <= psfc_pkg::STATUS_ANGLE;
			angle_q <= '0;
			error_q <= '0;
			data_err_q <= '0;
			frame_err_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				priority if (!frame_end.good) begin
					status_q <= psfc_pkg::STATUS_FRAME_BAD;
					if (frame_err_q != COUNT_TOP) frame_err_q <= frame_err_q + 1'b1;
				end else if (frame_end.word[0]) begin
					status_q <= psfc_pkg::STATUS_ANGLE;
					angle_q <= frame_end.word[psfc_pkg::WORD_W-1:2];
				end else begin
					status_q <= psfc_pkg::STATUS_SENSOR_ERR;
					error_q <= frame_end.word;
					if (data_err_q != COUNT_TOP) data_err_q <= data_err_q + 1'b1;
				end
			end
		end
	end

	assign out_valid = valid_q;
	assign out_status = status_q;
	assign out_angle = angle_q;
	assign out_error_word = error_q;

	// Tallies are shown as their low bits, zero-extended when narrower.
	generate
		if (COUNT_WIDTH >= psfc_pkg::OUT_COUNT_W) begin : g_cnt_trunc
			assign out_data_err_cnt = data_err_q[psfc_pkg::OUT_COUNT_W-1:0];
			assign out_frame_err_cnt = frame_err_q[psfc_pkg::OUT_COUNT_W-1:0];
		end else begin : g_cnt_ext
			assign out_data_err_cnt = {{(psfc_pkg::OUT_COUNT_W-COUNT_WIDTH){1'b0}}, data_err_q};
			assign out_frame_err_cnt = {{(psfc_pkg::OUT_COUNT_W-COUNT_WIDTH){1'b0}},
				frame_err_q};
		end
	endgenerate

	// The bad-frame tally never goes down.
	a_frame_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (frame_err_q >= $past(frame_err_q)))
		else $error("frame error tally decreased");

	// A good frame with an angle word reports an angle update.
	a_angle_status: assert property (@(posedge clk) disable iff (!arst_n)
		(load && frame_end.good && frame_end.word[0]) |=>
		(status_q == psfc_pkg::STATUS_ANGLE && valid_q))
		else $error("angle frame not reported");

	// A bad frame leaves the held angle and error word untouched.
	a_bad_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !frame_end.good) |=> ($stable(angle_q) && $stable(error_q)))
		else $error("bad frame changed held values");

endmodule

`default_nettype wire

// File: tb/frame_result_checker.sv
module frame_result_checker
	import psfc_pkg::*;
#(
	parameter int unsigned TALLY_W = COUNT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_valid,
	input logic s_ready,
	input logic [7:0] s_data,
	input logic s_user,
	input logic m_valid,
	input logic m_ready,
	input logic [63:0] m_data,
	input logic [1:0] m_user,
	output int mismatch_count,
	output int pending
);

	// One frame result as it should appear on the master side.
	typedef struct packed {
		status_t status;
		logic [ANGLE_W-1:0] angle;
		logic [WORD_W-1:0] error_word;
		logic [OUT_COUNT_W-1:0] sensor_count;
		logic [OUT_COUNT_W-1:0] bad_count;
	} frame_result_t;

	logic [POS_W-1:0] frame_pos;
	logic fill_good;
	logic inv_good;
	logic [BYTE_W-1:0] word_hi;
	logic [BYTE_W-1:0] word_lo;
	logic [ANGLE_W-1:0] kept_angle;
	logic [WORD_W-1:0] kept_error;
	logic [TALLY_W-1:0] sensor_tally;
	logic [TALLY_W-1:0] bad_tally;
	frame_result_t expected_results[$];

	function automatic logic [TALLY_W-1:0] bump_saturating(input logic [TALLY_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// Follow one accepted byte through the frame; a closing byte queues a result.
	task automatic predict_frame_byte(input logic [BYTE_W-1:0] b, input logic start);
		logic [WORD_W-1:0] word;
		frame_result_t res;
		if (start) begin
			frame_pos = '0;
			fill_good = 1'b1;
			inv_good = 1'b1;
		end else if (frame_pos >= POS_IDLE) begin
			// A stray byte with no frame open is dropped.
			frame_pos = POS_IDLE;
			return;
		end
		case (frame_pos)
			POS_DATA_HIGH: word_hi = b;
			POS_DATA_LOW: word_lo = b;
			POS_INV_HIGH: if (b != BYTE_W'(~word_hi)) inv_good = 1'b0;
			POS_INV_LOW: if (b != BYTE_W'(~word_lo)) inv_good = 1'b0;
			default: if (b != FILL_BYTE) fill_good = 1'b0;
		endcase
		if (frame_pos < POS_LAST) begin
			frame_pos = frame_pos + 1'b1;
			return;
		end
		frame_pos = POS_IDLE;
		word = {word_hi, word_lo};
		if (fill_good && inv_good) begin
			if (word[0]) begin
				kept_angle = word[WORD_W-1:2];
				res.status = STATUS_ANGLE;
			end else begin
				kept_error = word;
				sensor_tally = bump_saturating(sensor_tally);
				res.status = STATUS_SENSOR_ERR;
			end
		end else begin
			bad_tally = bump_saturating(bad_tally);
			res.status = STATUS_FRAME_BAD;
		end
		res.angle = kept_angle;
		res.error_word = kept_error;
		res.sensor_count = OUT_COUNT_W'(sensor_tally);
		res.bad_count = OUT_COUNT_W'(bad_tally);
		expected_results.push_back(res);
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// Compare a delivered result with the oldest one predicted.
	task automatic check_result();
		frame_result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result with no frame outstanding, expected none, actual %h / %h",
				$time, m_data, m_user);
			mismatch_count++;
			return;
		end
		want = expected_results.pop_front();
		check_field("frame_status", 32'(want.status), 32'(m_user));
		check_field("angle", 32'(want.angle), 32'(m_data[13:0]));
		check_field("error_word", 32'(want.error_word), 32'(m_data[29:14]));
		check_field("data_error_count", 32'(want.sensor_count), 32'(m_data[45:30]));
		check_field("frame_error_count", 32'(want.bad_count), 32'(m_data[61:46]));
		check_field("pad bits", 32'(0), 32'(m_data[63:62]));
	endtask

	// Results are checked before the byte of the same edge is absorbed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos = POS_IDLE;
			fill_good = 1'b1;
			inv_good = 1'b1;
			word_hi = '0;
			word_lo = '0;
			kept_angle = '0;
			kept_error = '0;
			sensor_tally = '0;
			bad_tally = '0;
			expected_results.delete();
			mismatch_count = 0;
			pending = 0;
		end else begin
			if (m_valid && m_ready)
				check_result();
			if (s_valid && s_ready)
				predict_frame_byte(s_data, s_user);
			pending = expected_results.size();
		end
	end

endmodule

// File: tb/tb.sv
module tb;
	import psfc_pkg::*;

	// Narrow tallies so that the zero-extended output path is exercised.
	localparam int unsigned TALLY_W = 8;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef enum int {
		FLAW_NONE,
		FLAW_FILL,
		FLAW_INV_HIGH,
		FLAW_INV_LOW
	} frame_flaw_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	int mismatch_count;
	int pending;
	bit hold_pending;

	position_sensor_frame_checker #(
		.COUNT_WIDTH(TALLY_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	frame_result_checker #(
		.TALLY_W(TALLY_W)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.s_data(s_axis_tdata),
		.s_user(s_axis_tuser),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.m_data(m_axis_tdata),
		.m_user(m_axis_tuser),
		.mismatch_count(mismatch_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one byte and return at the edge where the request is taken.
	task automatic send_byte(input logic [7:0] b, input logic start);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= start;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	// Build a reply frame, optionally spoil one check, and send its first bytes.
	task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo,
			input frame_flaw_t flaw, input int byte_count);
		logic [7:0] frame_bytes [10];
		int bad_pos;
		int i;
		for (i = 0; i < 10; i++)
			frame_bytes[i] = FILL_BYTE;
		frame_bytes[POS_DATA_HIGH] = hi;
		frame_bytes[POS_DATA_LOW] = lo;
		frame_bytes[POS_INV_HIGH] = ~hi;
		frame_bytes[POS_INV_LOW] = ~lo;
		case (flaw)
			FLAW_FILL: begin
				do bad_pos = $urandom_range(0, POS_LAST);
				while (bad_pos >= POS_DATA_HIGH && bad_pos <= POS_INV_LOW);
				frame_bytes[bad_pos] = 8'($urandom_range(0, 254));
			end
			FLAW_INV_HIGH: frame_bytes[POS_INV_HIGH] ^= 8'($urandom_range(1, 255));
			FLAW_INV_LOW: frame_bytes[POS_INV_LOW] ^= 8'($urandom_range(1, 255));
			default: ;
		endcase
		for (i = 0; i < byte_count; i++)
			send_byte(frame_bytes[i], i == 0);
	endtask

	function automatic frame_flaw_t pick_flaw();
		case ($urandom_range(0, 2))
			0: return FLAW_FILL;
			1: return FLAW_INV_HIGH;
			default: return FLAW_INV_LOW;
		endcase
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int counted;
		int n;
		int i;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		hold_pending = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: stray bytes while idle, a restart mid-frame, data word extremes.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_frame(8'h12, 8'h35, FLAW_NONE, 3);
		send_frame(8'hFF, 8'hFF, FLAW_NONE, 10);
		send_frame(8'h00, 8'h00, FLAW_NONE, 10);

		// Random: mostly well-formed frames, some spoiled, cut short or pure noise.
		hold_pending = 1'b1;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			n = $urandom_range(0, 99);
			if (n < 55) begin
				send_frame(8'($urandom), 8'($urandom), FLAW_NONE, 10);
				counted += 10;
			end else if (n < 75) begin
				send_frame(8'($urandom), 8'($urandom), pick_flaw(), 10);
				counted += 10;
			end else if (n < 85) begin
				i = $urandom_range(1, 9);
				send_frame(8'($urandom), 8'($urandom), FLAW_NONE, i);
				counted += i;
			end else if (n < 92) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
			end else begin
				send_byte(8'($urandom), 1'b1);
				repeat (9) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
				counted += 10;
			end
		end

		// Close with a few angle frames after the mixed traffic.
		repeat (3) send_frame(8'($urandom), {7'($urandom), 1'b1}, FLAW_NONE, 10);

		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#6000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
